// ===== src/octagon_gate_stick_mapper_defines.svh =====
// ----------------------------------------------------------------------------
// Octagon gate stick mapper - assertion macros
// Shared check macros, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OCTAGON_GATE_STICK_MAPPER_DEFINES_SVH
`define OCTAGON_GATE_STICK_MAPPER_DEFINES_SVH

// same-cycle implication
`define OGSM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("ogsm check failed");

// next-cycle implication
`define OGSM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("ogsm check failed");

`endif

// ===== src/ogsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Octagon gate stick mapper - package
// Fixed-point constants, register indexes and pipeline side-band types.
// ----------------------------------------------------------------------------
package ogsm_pkg;

    // register indexes
    localparam logic CFG_MAX_CARDINAL = 1'b0;
    localparam logic CFG_MAX_RADIUS   = 1'b1;

    localparam logic [7:0]  CARD_LIMIT   = 8'd85;
    localparam logic [15:0] RADIUS_FLOOR = 16'd24981;   // 97.58 in Q8.8
    localparam logic [15:0] SCALE_ONE    = 16'd32768;   // 1.0 in Q1.15
    localparam logic [13:0] SLOPE_Q16    = 14'd15197;   // 16/69 in Q0.16
    localparam logic [15:0] EDGE_Q8      = 16'd21760;   // 85.0 in Q8.8
    localparam logic [15:0] EDGE2_Q8     = 16'd43520;   // twice the edge

    // quotient bits of the clamp divider (result never exceeds 21760)
    localparam int QUOT_W = 15;

    // accept edge to result strobe
    localparam int PIPE_LATENCY = 23;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic xzero;
        logic yzero;
        logic xmajor;
    } flags_t;

    typedef struct packed {
        flags_t      flags;
        logic        clamp;
        logic [15:0] hi;
        logic [15:0] lo;
    } side_t;

endpackage

// ===== src/octagon_gate_stick_mapper.sv =====
// ----------------------------------------------------------------------------
// Octagon gate stick mapper - top level
// Maps a signed stick sample onto an octagonal gate of extent 85.
//
//   channel   ports                          transfer
//   input     start, busy, x_in, y_in        start high, busy low
//   result    done, x_out, y_out             done high, one cycle
//   config    cfg_we, cfg_index, cfg_data    cfg_we high
//
// One sample per cycle while busy is low; done follows the accepting edge
// through the front stages, the 15-stage clamp divider and the back stages.
// A register write holds busy high while the bit-serial scale divider runs
// both quotients, one after the other.
// Reset loads both registers with their floors and a scale of 1.0.
// The receiver cannot stall; results leave on the cycle they are ready.
// ----------------------------------------------------------------------------
`include "octagon_gate_stick_mapper_defines.svh"

module octagon_gate_stick_mapper (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [7:0] x_in,
    input  logic signed [7:0] y_in,
    output logic              done,
    output logic signed [7:0] x_out,
    output logic signed [7:0] y_out,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data
);
    import ogsm_pkg::*;

    logic              accept;
    logic [15:0]       scale;
    logic              fr_valid;
    logic [30:0]       fr_num;
    logic [16:0]       fr_den;
    side_t             fr_side;
    logic              dv_valid;
    logic [QUOT_W-1:0] dv_quot;
    side_t             dv_side;

    assign accept = start && !busy;

    ogsm_scale_unit u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scale     (scale),
        .busy      (busy)
    );

    ogsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .x_in      (x_in),
        .y_in      (y_in),
        .scale     (scale),
        .out_valid (fr_valid),
        .num       (fr_num),
        .den       (fr_den),
        .side      (fr_side)
    );

    ogsm_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .num       (fr_num),
        .den       (fr_den),
        .in_side   (fr_side),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_side  (dv_side)
    );

    ogsm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dv_valid),
        .quot     (dv_quot),
        .side     (dv_side),
        .done     (done),
        .x_out    (x_out),
        .y_out    (y_out)
    );

    `OGSM_ASSERT_IMPL(a_x_range, done, (x_out >= -8'sd85 && x_out <= 8'sd85))
    `OGSM_ASSERT_IMPL(a_y_range, done, (y_out >= -8'sd85 && y_out <= 8'sd85))
    `OGSM_ASSERT_IMPL(a_x_zero, accept && x_in == 8'sd0, ##PIPE_LATENCY (done && x_out == 8'sd0))

endmodule

// ===== src/ogsm_scale_unit.sv =====
// ----------------------------------------------------------------------------
// Octagon gate stick mapper - scale unit
// Holds the two registers and derives the Q1.15 scale with a bit-serial
// divider, one quotient bit per cycle, whenever a register is written.
// ----------------------------------------------------------------------------
`include "octagon_gate_stick_mapper_defines.svh"

module ogsm_scale_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic [15:0] scale,
    output logic        busy
);
    import ogsm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_DIV_C = 2'd2;
    localparam logic [1:0] ST_DIV_R = 2'd3;

    localparam logic [4:0] LAST_STEP = 5'd29;

    logic [7:0]  card_reg, card_next;
    logic [15:0] rad_reg, rad_next;
    logic [15:0] scale_reg, scale_next;
    logic [1:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [29:0] numq_reg, numq_next;
    logic [15:0] den_reg, den_next;
    logic [15:0] sc_reg, sc_next;

    logic [7:0]  card_eff;
    logic [15:0] rad_eff;
    logic [29:0] num_card;
    logic [29:0] num_rad;
    logic [16:0] trial;
    logic        ge;
    logic [16:0] diff;
    logic [15:0] step_rem;
    logic [29:0] step_q;

    assign card_eff = (card_reg < CARD_LIMIT) ? CARD_LIMIT : card_reg;
    assign rad_eff  = (rad_reg < RADIUS_FLOOR) ? RADIUS_FLOOR : rad_reg;

    // round to nearest: add half the divisor
    assign num_card = 30'({CARD_LIMIT, 15'b0}) + 30'(card_eff[7:1]);
    assign num_rad  = 30'({RADIUS_FLOOR, 15'b0}) + 30'(rad_eff[15:1]);

    // restoring step; quotient bits shift in from the bottom
    assign trial    = {rem_reg, numq_reg[29]};
    assign ge       = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    assign step_rem = ge ? diff[15:0] : trial[15:0];
    assign step_q   = {numq_reg[28:0], ge};

    always_comb
    begin
        card_next  = card_reg;
        rad_next   = rad_reg;
        scale_next = scale_reg;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        numq_next  = numq_reg;
        den_next   = den_reg;
        sc_next    = sc_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_CARDINAL: card_next = cfg_data[7:0];
                CFG_MAX_RADIUS:   rad_next  = cfg_data;
                default: ;
            endcase
            state_next = ST_LOAD;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    rem_next   = 16'd0;
                    numq_next  = num_card;
                    den_next   = {8'd0, card_eff};
                    cnt_next   = 5'd0;
                    state_next = ST_DIV_C;
                end
                ST_DIV_C, ST_DIV_R:
                begin
                    rem_next  = step_rem;
                    numq_next = step_q;
                    cnt_next  = cnt_reg + 5'd1;
                    if (cnt_reg == LAST_STEP)
                    begin
                        cnt_next = 5'd0;
                        if (state_reg == ST_DIV_C)
                        begin
                            sc_next    = step_q[15:0];
                            rem_next   = 16'd0;
                            numq_next  = num_rad;
                            den_next   = rad_eff;
                            state_next = ST_DIV_R;
                        end
                        else
                        begin
                            scale_next = (sc_reg > step_q[15:0]) ? sc_reg : step_q[15:0];
                            state_next = ST_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_reg  <= CARD_LIMIT;
            rad_reg   <= RADIUS_FLOOR;
            scale_reg <= SCALE_ONE;
            state_reg <= ST_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            card_reg  <= card_next;
            rad_reg   <= rad_next;
            scale_reg <= scale_next;
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        numq_reg <= numq_next;
        den_reg  <= den_next;
        sc_reg   <= sc_next;
    end

    assign scale = scale_reg;
    assign busy  = state_reg != ST_IDLE;

    `OGSM_ASSERT_NEXT(a_cfg_busy, cfg_we, busy)
    `OGSM_ASSERT_IMPL(a_scale_range, 1'b1, (scale_reg <= SCALE_ONE && scale_reg != 16'd0))
    `OGSM_ASSERT_IMPL(a_idle_cnt, state_reg == ST_IDLE, (cnt_reg == 5'd0))

endmodule

// ===== src/ogsm_front.sv =====
// ----------------------------------------------------------------------------
// Octagon gate stick mapper - front pipeline
// Folds, scales and orders the sample, forms the gate edge sum and sets up
// the clamp division operands. Six register stages.
// ----------------------------------------------------------------------------
module ogsm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [7:0]   x_in,
    input  logic signed [7:0]   y_in,
    input  logic [15:0]         scale,
    output logic                out_valid,
    output logic [30:0]         num,
    output logic [16:0]         den,
    output ogsm_pkg::side_t     side
);
    import ogsm_pkg::*;

    logic [5:0] v_reg;

    // stage 0: magnitudes
    logic [7:0] xu, yu, ax_c, ay_c;
    logic [7:0] ax_reg, ay_reg;
    flags_t     f0_reg;
    // stage 1: scaled Q8.8
    logic [23:0] px, py, rx, ry;
    logic [15:0] sx_reg, sy_reg;
    flags_t      f1_reg;
    // stage 2: ordered
    logic [15:0] hi2_reg, lo2_reg;
    flags_t      f2_reg;
    // stage 3: slope product
    logic [29:0] pt, rt;
    logic [12:0] t3_reg;
    logic [15:0] hi3_reg, lo3_reg;
    flags_t      f3_reg;
    // stage 4: edge sum
    logic [16:0] bsum;
    logic [15:0] b4_reg, hi4_reg, lo4_reg;
    logic        clamp4_reg;
    flags_t      f4_reg;
    // stage 5: division operands
    logic [30:0] num_c;
    logic [30:0] num_reg;
    logic [16:0] den_reg;
    side_t       side_reg;

    assign xu   = x_in;
    assign yu   = y_in;
    // -128 folds to 128, which fits unsigned
    assign ax_c = xu[7] ? (~xu + 8'd1) : xu;
    assign ay_c = yu[7] ? (~yu + 8'd1) : yu;

    assign px = {16'd0, ax_reg} * {8'd0, scale};
    assign py = {16'd0, ay_reg} * {8'd0, scale};
    assign rx = px + 24'd64;
    assign ry = py + 24'd64;

    assign pt = {14'd0, lo2_reg} * {16'd0, SLOPE_Q16};
    assign rt = pt + 30'd32768;

    assign bsum = {1'b0, hi3_reg} + {4'd0, t3_reg};

    assign num_c = {15'd0, lo4_reg} * {15'd0, EDGE2_Q8} + {15'd0, b4_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        ax_reg        <= ax_c;
        ay_reg        <= ay_c;
        f0_reg.xneg   <= xu[7];
        f0_reg.yneg   <= yu[7];
        f0_reg.xzero  <= xu == 8'd0;
        f0_reg.yzero  <= yu == 8'd0;
        f0_reg.xmajor <= ax_c > ay_c;

        sx_reg <= rx[22:7];
        sy_reg <= ry[22:7];
        f1_reg <= f0_reg;

        hi2_reg <= (sx_reg > sy_reg) ? sx_reg : sy_reg;
        lo2_reg <= (sx_reg < sy_reg) ? sx_reg : sy_reg;
        f2_reg  <= f1_reg;

        t3_reg  <= rt[28:16];
        hi3_reg <= hi2_reg;
        lo3_reg <= lo2_reg;
        f3_reg  <= f2_reg;

        b4_reg     <= bsum[15:0];
        clamp4_reg <= bsum[15:0] > EDGE_Q8;
        hi4_reg    <= hi3_reg;
        lo4_reg    <= lo3_reg;
        f4_reg     <= f3_reg;

        num_reg        <= num_c;
        den_reg        <= {b4_reg, 1'b0};
        side_reg.flags <= f4_reg;
        side_reg.clamp <= clamp4_reg;
        side_reg.hi    <= hi4_reg;
        side_reg.lo    <= lo4_reg;
    end

    assign out_valid = v_reg[5];
    assign num       = num_reg;
    assign den       = den_reg;
    assign side      = side_reg;

endmodule

// ===== src/ogsm_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Octagon gate stick mapper - clamp divider
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit QUOT_W bits, so the top numerator bits seed the remainder.
// ----------------------------------------------------------------------------
module ogsm_div_pipe (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [30:0]             num,
    input  logic [16:0]             den,
    input  ogsm_pkg::side_t         in_side,
    output logic                    out_valid,
    output logic [ogsm_pkg::QUOT_W-1:0] quot,
    output ogsm_pkg::side_t         out_side
);
    import ogsm_pkg::*;

    logic [QUOT_W-1:0] v_reg;
    logic [16:0]       rem_reg  [QUOT_W];
    logic [QUOT_W-1:0] bits_reg [QUOT_W];
    logic [16:0]       den_reg  [QUOT_W];
    side_t             side_reg [QUOT_W];

    logic [16:0]       rem_i    [QUOT_W];
    logic [QUOT_W-1:0] bits_i   [QUOT_W];
    logic [16:0]       den_i    [QUOT_W];
    side_t             side_i   [QUOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[QUOT_W-2:0], in_valid};
    end

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_stage
        logic [17:0] trial;
        logic [17:0] diff;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign rem_i[k]  = {1'b0, num[30:QUOT_W]};
            assign bits_i[k] = num[QUOT_W-1:0];
            assign den_i[k]  = den;
            assign side_i[k] = in_side;
        end
        else
        begin : g_next
            assign rem_i[k]  = rem_reg[k-1];
            assign bits_i[k] = bits_reg[k-1];
            assign den_i[k]  = den_reg[k-1];
            assign side_i[k] = side_reg[k-1];
        end

        assign trial = {rem_i[k], bits_i[k][QUOT_W-1]};
        assign ge    = trial >= {1'b0, den_i[k]};
        assign diff  = trial - {1'b0, den_i[k]};

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? diff[16:0] : trial[16:0];
            bits_reg[k] <= {bits_i[k][QUOT_W-2:0], ge};
            den_reg[k]  <= den_i[k];
            side_reg[k] <= side_i[k];
        end
    end

    assign out_valid = v_reg[QUOT_W-1];
    assign quot      = bits_reg[QUOT_W-1];
    assign out_side  = side_reg[QUOT_W-1];

endmodule

// ===== src/ogsm_back.sv =====
// ----------------------------------------------------------------------------
// Octagon gate stick mapper - back end
// Rebuilds the major coordinate on the gate edge for clamped samples, rounds
// half to even and restores octant and quadrant. Two register stages.
// ----------------------------------------------------------------------------
module ogsm_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [ogsm_pkg::QUOT_W-1:0] quot,
    input  ogsm_pkg::side_t             side,
    output logic                        done,
    output logic signed [7:0]           x_out,
    output logic signed [7:0]           y_out
);
    import ogsm_pkg::*;

    function automatic logic [7:0] round_even(input logic [15:0] v);
        logic up;
        up = (v[7:0] > 8'd128) || (v[7:0] == 8'd128 && v[8]);
        return v[15:8] + {7'd0, up};
    endfunction

    logic [1:0]        v_reg;
    logic [28:0]       ps, rs;
    logic [12:0]       s_reg;
    logic [QUOT_W-1:0] q_reg;
    side_t             side_reg;

    logic [15:0] hi_f, lo_f;
    logic [7:0]  rhi, rlo, ox, oy, sx, sy;
    logic signed [7:0] x_out_reg, y_out_reg;

    assign ps = {14'd0, quot} * {15'd0, SLOPE_Q16};
    assign rs = ps + 29'd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 2'b00;
        else
            v_reg <= {v_reg[0], in_valid};
    end

    always_comb
    begin
        hi_f = side_reg.clamp ? (EDGE_Q8 - {3'd0, s_reg}) : side_reg.hi;
        lo_f = side_reg.clamp ? {{(16-QUOT_W){1'b0}}, q_reg} : side_reg.lo;
        rhi  = round_even(hi_f);
        rlo  = round_even(lo_f);
        ox   = side_reg.flags.xmajor ? rhi : rlo;
        oy   = side_reg.flags.xmajor ? rlo : rhi;
        if (side_reg.flags.xzero)
            ox = 8'd0;
        if (side_reg.flags.yzero)
            oy = 8'd0;
        sx = side_reg.flags.xneg ? (~ox + 8'd1) : ox;
        sy = side_reg.flags.yneg ? (~oy + 8'd1) : oy;
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= rs[28:16];
        q_reg     <= quot;
        side_reg  <= side;
        x_out_reg <= sx;
        y_out_reg <= sy;
    end

    assign done  = v_reg[1];
    assign x_out = x_out_reg;
    assign y_out = y_out_reg;

endmodule
